// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the console writer checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCW_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCCW_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hw/rtl/tccw_pkg.sv
// ---------------------------------------------------------------------------
// Console cell writer package
// Request and result types, function codes and character codes.
// ---------------------------------------------------------------------------
package tccw_pkg;

  localparam int CellW   = 16;
  localparam int CursorW = 11;
  localparam int AddrW   = 11;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       char_code;
    logic [7:0]       attribute;
    logic [AddrW-1:0] read_address;
  } req_t;

  typedef struct packed {
    logic [CursorW-1:0] cursor_position;
    logic [CellW-1:0]   cell_value;
  } rsp_t;

endpackage

// File: hw/rtl/text_console_cell_writer_core.sv
// Request paths to the result strobe: printable, backspace, unused code and out-of-range read
// finish from idle; read passes through S_READ; newline, return and tab step through the
// cells in S_NL, S_CR or S_TAB; a scroll adds S_SCP and S_SBL; clear runs through S_CLR.
// The single write port of the cell RAM sets the pace: one cell written per cycle.
// One request in flight; the strobe cycle already accepts the next. No result back-pressure.
// Reset homes the cursor and sets the blank attribute to 7; cell contents are undefined.
// ---------------------------------------------------------------------------
// Text console cell writer
// Character-cell console over a COLUMNS x ROWS cell RAM with scroll and clear.
// ---------------------------------------------------------------------------
module text_console_cell_writer_core #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tccw_pkg::req_t req_i,
  output logic          result_valid_o,
  output tccw_pkg::rsp_t result_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i
);

  localparam int CellCount  = COLUMNS * ROWS;
  localparam int AW         = $clog2(CellCount);
  localparam int CW         = $clog2(CellCount + 1);
  localparam int ColW       = $clog2(COLUMNS);
  localparam int TabW       = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int ColsModTab = COLUMNS % TAB_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_NL   = 3'd2;
  localparam logic [2:0] S_CR   = 3'd3;
  localparam logic [2:0] S_TAB  = 3'd4;
  localparam logic [2:0] S_SCP  = 3'd5;
  localparam logic [2:0] S_SBL  = 3'd6;
  localparam logic [2:0] S_CLR  = 3'd7;

  logic [2:0]                 state_q, state_d;
  logic [CW-1:0]              cursor_q, cursor_d;
  logic [ColW-1:0]            col_q, col_d;
  logic [TabW-1:0]            tcol_q, tcol_d;
  logic [AW-1:0]              ptr_q, ptr_d;
  logic [tccw_pkg::CellW-1:0] blank_q, blank_d;
  logic [7:0]                 blank_attr_q;
  logic                       cp_pend_q, cp_pend_d;
  logic [AW-1:0]              cp_addr_q, cp_addr_d;
  logic                       done_q, done_d;
  tccw_pkg::rsp_t             result_q, result_d;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [tccw_pkg::CellW-1:0] mem_wdata, mem_rdata;

  logic                       fin;
  logic [CW-1:0]              fin_cursor;
  logic [tccw_pkg::CellW-1:0] fin_value;

  logic [CW-1:0]              cur_inc, cur_dec;
  logic [ColW-1:0]            col_inc, col_dec;
  logic [TabW-1:0]            tcol_inc, tcol_dec, tcol_scr;
  logic [AW-1:0]              cur_addr;
  logic [tccw_pkg::CellW-1:0] cfg_blank;
  logic                       rd_in_range;

  assign cur_inc  = cursor_q + CW'(1);
  assign cur_dec  = cursor_q - CW'(1);
  assign col_inc  = (col_q == ColW'(COLUMNS - 1)) ? '0 : col_q + ColW'(1);
  assign col_dec  = (col_q == '0) ? ColW'(COLUMNS - 1) : col_q - ColW'(1);
  assign tcol_inc = (tcol_q == TabW'(TAB_WIDTH - 1)) ? '0 : tcol_q + TabW'(1);
  assign tcol_dec = (tcol_q == '0) ? TabW'(TAB_WIDTH - 1) : tcol_q - TabW'(1);
  // cursor drops by COLUMNS on scroll: keep the tab phase in step
  assign tcol_scr = (tcol_q >= TabW'(ColsModTab)) ? tcol_q - TabW'(ColsModTab)
                                                  : tcol_q + TabW'(TAB_WIDTH - ColsModTab);
  assign cur_addr  = AW'(cursor_q);
  assign cfg_blank = {blank_attr_q, tccw_pkg::CHAR_SPACE};
  assign rd_in_range = 32'(req_i.read_address) < 32'(CellCount);

  always_comb begin
    state_d    = state_q;
    cursor_d   = cursor_q;
    col_d      = col_q;
    tcol_d     = tcol_q;
    ptr_d      = ptr_q;
    blank_d    = blank_q;
    cp_pend_d  = 1'b0;
    cp_addr_d  = ptr_q;
    done_d     = 1'b0;
    result_d   = result_q;
    fin        = 1'b0;
    fin_cursor = cursor_q;
    fin_value  = '0;
    // trailing write of the scroll copy owns the port while pending
    mem_we     = cp_pend_q;
    mem_waddr  = cp_addr_q;
    mem_wdata  = mem_rdata;
    mem_raddr  = ptr_q + AW'(COLUMNS);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (req_i.func)
            tccw_pkg::FUNC_PUT: begin
              blank_d = {req_i.attribute, tccw_pkg::CHAR_SPACE};
              case (req_i.char_code)
                tccw_pkg::CHAR_NL:  state_d = S_NL;
                tccw_pkg::CHAR_CR:  state_d = S_CR;
                tccw_pkg::CHAR_TAB: state_d = S_TAB;
                tccw_pkg::CHAR_BS: begin
                  if (cursor_q != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_addr;
                    mem_wdata = {req_i.attribute, tccw_pkg::CHAR_SPACE};
                    cursor_d  = cur_dec;
                    col_d     = col_dec;
                    tcol_d    = tcol_dec;
                  end
                  fin        = 1'b1;
                  fin_cursor = cursor_d;
                end
                default: begin
                  mem_we     = 1'b1;
                  mem_waddr  = cur_addr;
                  mem_wdata  = {req_i.attribute, req_i.char_code};
                  cursor_d   = cur_inc;
                  col_d      = col_inc;
                  tcol_d     = tcol_inc;
                  fin        = 1'b1;
                  fin_cursor = cur_inc;
                end
              endcase
            end
            tccw_pkg::FUNC_CLEAR: begin
              state_d  = S_CLR;
              ptr_d    = '0;
              cursor_d = '0;
              col_d    = '0;
              tcol_d   = '0;
            end
            tccw_pkg::FUNC_READ: begin
              mem_raddr = AW'(req_i.read_address);
              if (rd_in_range) begin
                state_d = S_READ;
              end else begin
                fin = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end

      S_READ: begin
        fin       = 1'b1;
        fin_value = mem_rdata;
      end

      S_NL: begin
        mem_we    = 1'b1;
        mem_waddr = cur_addr;
        mem_wdata = blank_q;
        cursor_d  = cur_inc;
        col_d     = col_inc;
        tcol_d    = tcol_inc;
        if (col_q == ColW'(COLUMNS - 1)) begin
          fin        = 1'b1;
          fin_cursor = cur_inc;
        end
      end

      S_CR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_addr;
        mem_wdata = blank_q;
        if (col_q == '0) begin
          fin = 1'b1;
        end else begin
          cursor_d = cur_dec;
          col_d    = col_dec;
          tcol_d   = tcol_dec;
          if (col_q == ColW'(1)) begin
            fin        = 1'b1;
            fin_cursor = cur_dec;
          end
        end
      end

      S_TAB: begin
        mem_we    = 1'b1;
        mem_waddr = cur_addr;
        mem_wdata = blank_q;
        cursor_d  = cur_inc;
        col_d     = col_inc;
        tcol_d    = tcol_inc;
        if (tcol_inc == '0 || cur_inc == CW'(CellCount)) begin
          fin        = 1'b1;
          fin_cursor = cur_inc;
        end
      end

      // copy row r+1 into row r: read runs one entry ahead of the write
      S_SCP: begin
        cp_pend_d = 1'b1;
        cp_addr_d = ptr_q;
        if (ptr_q == AW'(CellCount - COLUMNS - 1)) begin
          state_d = S_SBL;
          ptr_d   = AW'(CellCount - COLUMNS);
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end

      S_SBL: begin
        if (!cp_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_q;
          mem_wdata = cfg_blank;
          if (ptr_q == AW'(CellCount - 1)) begin
            cursor_d   = cursor_q - CW'(COLUMNS);
            tcol_d     = tcol_scr;
            fin        = 1'b1;
            fin_cursor = cursor_q - CW'(COLUMNS);
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end
      end

      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = cfg_blank;
        if (ptr_q == AW'(CellCount - 1)) begin
          fin = 1'b1;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      if (fin_cursor == CW'(CellCount)) begin
        state_d = S_SCP;
        ptr_d   = '0;
      end else begin
        state_d                  = S_IDLE;
        done_d                   = 1'b1;
        result_d.cursor_position = tccw_pkg::CursorW'(fin_cursor);
        result_d.cell_value      = fin_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cursor_q     <= '0;
      col_q        <= '0;
      tcol_q       <= '0;
      ptr_q        <= '0;
      blank_attr_q <= 8'd7;
      cp_pend_q    <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      cursor_q  <= cursor_d;
      col_q     <= col_d;
      tcol_q    <= tcol_d;
      ptr_q     <= ptr_d;
      cp_pend_q <= cp_pend_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        blank_attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blank_q   <= blank_d;
    cp_addr_q <= cp_addr_d;
    result_q  <= result_d;
  end

  tccw_ram #(
    .WIDTH (tccw_pkg::CellW),
    .DEPTH (CellCount)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = done_q;
  assign result_o       = result_q;

endmodule

// File: hw/rtl/tccw_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tccw_checker.sv
// ---------------------------------------------------------------------------
// Console cell writer checker
// Port-level checks on request acceptance and result strobes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tccw_checker #(
  parameter int CellCount = 2000
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input tccw_pkg::req_t req_i,
  input logic           result_valid_o,
  input tccw_pkg::rsp_t result_o
);

  logic accepted;
  assign accepted = start && !busy;

  // strobe only once the engine has returned to idle
  `TCCW_ASSERT_IMP(a_strobe_idle, clk_i, rst_ni, result_valid_o, !busy)
  // an accepted request either answers next cycle or keeps the engine busy
  `TCCW_ASSERT_NXT(a_accept_progress, clk_i, rst_ni, accepted, busy || result_valid_o)
  // reported cursor always lies inside the buffer
  `TCCW_ASSERT_IMP(a_cursor_range, clk_i, rst_ni, result_valid_o,
                   32'(result_o.cursor_position) < 32'(CellCount))
  // nonzero cell data only comes from a RAM read, which goes through the busy S_READ state
  `TCCW_ASSERT_IMP(a_read_latency, clk_i, rst_ni,
                   result_valid_o && (result_o.cell_value != '0), $past(busy))

endmodule

bind text_console_cell_writer_core tccw_checker #(
  .CellCount (COLUMNS * ROWS)
) u_tccw_checker (.*);

// File: bench/tb_text_console_cell_writer_core.sv
// ---------------------------------------------------------------------------
// Console cell writer testbench
// Drives put, clear and read requests into the core. A cell-accurate screen
// and cursor predictor checks every result strobe in order. The run covers the
// control characters, scrolling at the buffer end and several blank attributes.
// ---------------------------------------------------------------------------
module tb_text_console_cell_writer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Columns   = 80;
  localparam int Rows      = 25;
  localparam int TabWidth  = 8;
  localparam int CellCount = Columns * Rows;

  localparam logic [1:0] FuncUnused = 2'd3;

  logic           clk_i          = 1'b0;
  logic           rst_ni         = 1'b0;
  logic           start          = 1'b0;
  logic           busy;
  tccw_pkg::req_t req_i          = '0;
  logic           result_valid_o;
  tccw_pkg::rsp_t result_o;
  logic           cfg_we_i       = 1'b0;
  logic [7:0]     cfg_wdata_i    = '0;

  text_console_cell_writer_core #(
    .COLUMNS  (Columns),
    .ROWS     (Rows),
    .TAB_WIDTH(TabWidth)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // screen and cursor as the core should hold them
  logic [15:0] screen_model [CellCount];
  int unsigned cursor_model     = 0;
  logic [7:0]  blank_attr_model = 8'd7;

  tccw_pkg::rsp_t expected_report_q [$];
  int unsigned sender_idle_pct  = 0;
  int unsigned errors           = 0;
  int unsigned requests_sent    = 0;
  int unsigned reports_checked  = 0;
  int unsigned scrolls_seen     = 0;
  int unsigned clears_seen      = 0;
  int unsigned attr_settings    = 1;

  initial begin
    for (int i = 0; i < CellCount; i++) screen_model[i] = '0;
  end

  function automatic void store_cell(int unsigned idx, logic [15:0] value);
    if (idx < CellCount) screen_model[idx] = value;
  endfunction

  function automatic tccw_pkg::rsp_t apply_console_request(tccw_pkg::req_t r);
    tccw_pkg::rsp_t rsp;
    logic [15:0]    blank;
    rsp   = '0;
    blank = {r.attribute, tccw_pkg::CHAR_SPACE};
    case (r.func)
      tccw_pkg::FUNC_PUT: begin
        case (r.char_code)
          tccw_pkg::CHAR_NL: begin
            do begin
              store_cell(cursor_model, blank);
              cursor_model++;
            end while (cursor_model % Columns != 0);
          end
          tccw_pkg::CHAR_CR: begin
            // row start itself is left alone unless the cursor sits on it
            store_cell(cursor_model, blank);
            while (cursor_model % Columns != 0) begin
              cursor_model--;
              if (cursor_model % Columns != 0) store_cell(cursor_model, blank);
            end
          end
          tccw_pkg::CHAR_BS: begin
            if (cursor_model != 0) begin
              store_cell(cursor_model, blank);
              cursor_model--;
            end
          end
          tccw_pkg::CHAR_TAB: begin
            do begin
              store_cell(cursor_model, blank);
              cursor_model++;
            end while (cursor_model % TabWidth != 0 && cursor_model < CellCount);
          end
          default: begin
            store_cell(cursor_model, {r.attribute, r.char_code});
            cursor_model++;
          end
        endcase
        if (cursor_model >= CellCount) begin
          for (int i = 0; i < CellCount - Columns; i++)
            screen_model[i] = screen_model[i + Columns];
          for (int i = CellCount - Columns; i < CellCount; i++)
            screen_model[i] = {blank_attr_model, tccw_pkg::CHAR_SPACE};
          cursor_model -= Columns;
          scrolls_seen++;
        end
      end
      tccw_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < CellCount; i++)
          screen_model[i] = {blank_attr_model, tccw_pkg::CHAR_SPACE};
        cursor_model = 0;
        clears_seen++;
      end
      tccw_pkg::FUNC_READ: begin
        if (r.read_address < CellCount) rsp.cell_value = screen_model[r.read_address];
      end
      default: ;
    endcase
    rsp.cursor_position = cursor_model[tccw_pkg::CursorW-1:0];
    return rsp;
  endfunction

  // result strobes cannot be held off: check each one as it comes
  always @(posedge clk_i) begin
    tccw_pkg::rsp_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_report_q.size() == 0) begin
        $error("result with no request outstanding: cursor_position %0d cell_value %h",
               result_o.cursor_position, result_o.cell_value);
        errors++;
      end else begin
        want = expected_report_q.pop_front();
        reports_checked++;
        if (result_o.cursor_position !== want.cursor_position) begin
          $error("cursor_position: expected %0d, got %0d",
                 want.cursor_position, result_o.cursor_position);
          errors++;
        end
        if (result_o.cell_value !== want.cell_value) begin
          $error("cell_value: expected %h, got %h", want.cell_value, result_o.cell_value);
          errors++;
        end
      end
    end
  end

  task automatic send_request(logic [1:0] func, logic [7:0] code, logic [7:0] attr,
                              logic [tccw_pkg::AddrW-1:0] addr);
    tccw_pkg::req_t r;
    int unsigned    gap;
    r.func         = func;
    r.char_code    = code;
    r.attribute    = attr;
    r.read_address = addr;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    expected_report_q.push_back(apply_console_request(r));
    requests_sent++;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      // mostly short gaps, now and then long enough to span a row fill
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic finish_phase(int unsigned settle);
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_report_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_blank_attr(logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    blank_attr_model = value;
    attr_settings++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_printable();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == tccw_pkg::CHAR_NL || c == tccw_pkg::CHAR_CR ||
           c == tccw_pkg::CHAR_BS || c == tccw_pkg::CHAR_TAB);
    return c;
  endfunction

  task automatic put_char(logic [7:0] code);
    send_request(tccw_pkg::FUNC_PUT, code, 8'($urandom_range(0, 255)),
                 11'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(logic [tccw_pkg::AddrW-1:0] addr);
    send_request(tccw_pkg::FUNC_READ, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), addr);
  endtask

  // walk forward on the current screen using tabs where they land at or short of target
  task automatic advance_to(int unsigned target);
    while (cursor_model < target) begin
      if ((cursor_model / TabWidth + 1) * TabWidth <= target) put_char(tccw_pkg::CHAR_TAB);
      else put_char(random_printable());
    end
  endtask

  task automatic test_directed();
    send_request(tccw_pkg::FUNC_PUT, 8'h00, 8'h00, 11'h000);
    send_request(tccw_pkg::FUNC_PUT, 8'hFF, 8'hFF, 11'h7FF);
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'h7FF);                       // past the buffer: reads as 0
    send_request(FuncUnused, 8'hFF, 8'hFF, 11'h7FF);
    send_request(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_BS, 8'h12, 11'd0);
    read_cell(11'd2);
    send_request(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_BS, 8'h34, 11'd0);
    send_request(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_BS, 8'h56, 11'd0);   // at home: no effect
    send_request(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_CR, 8'h9A, 11'd0);   // at column 0
    send_request(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_TAB, 8'h3C, 11'd0);
    send_request(tccw_pkg::FUNC_PUT, 8'h78, 8'h1E, 11'd0);
    send_request(tccw_pkg::FUNC_PUT, 8'h79, 8'h2F, 11'd0);
    send_request(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_TAB, 8'h4B, 11'd0);  // from mid tab stop
    send_request(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_CR, 8'h5D, 11'd0);
    read_cell(11'd0);
    send_request(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_NL, 8'h6E, 11'd0);   // newline from column 0
    send_request(tccw_pkg::FUNC_PUT, 8'h41, 8'hC3, 11'd0);
    send_request(tccw_pkg::FUNC_PUT, tccw_pkg::CHAR_NL, 8'hA5, 11'd0);
    read_cell(11'd81);
    read_cell(11'd80);
    send_request(tccw_pkg::FUNC_CLEAR, 8'h00, 8'h00, 11'd0);  // blank attribute still at reset
    read_cell(11'd1999);
    read_cell(11'd1024);
  endtask

  task automatic test_scroll();
    while (cursor_model < (Rows - 1) * Columns) begin
      repeat ($urandom_range(0, 2)) put_char(random_printable());
      put_char(tccw_pkg::CHAR_NL);
    end
    advance_to(CellCount - 1);
    put_char(random_printable());           // last cell written, then scroll
    read_cell(11'(CellCount - Columns - 1));
    read_cell(11'(CellCount - 1));
    put_char(tccw_pkg::CHAR_NL);            // newline at start of last row
    read_cell(11'(CellCount - 1));
    advance_to(CellCount - TabWidth);
    put_char(tccw_pkg::CHAR_TAB);           // tab runs into the buffer end
    advance_to(CellCount - 5);
    put_char(tccw_pkg::CHAR_TAB);
    advance_to(CellCount - 1);
    put_char(tccw_pkg::CHAR_NL);            // newline in the last column
    put_char(tccw_pkg::CHAR_BS);            // back across the row boundary
    put_char(tccw_pkg::CHAR_CR);
    read_cell(11'(cursor_model + 1));
    read_cell(11'(cursor_model));
    put_char(tccw_pkg::CHAR_TAB);
  endtask

  task automatic test_random_text(int unsigned count);
    int unsigned pick;
    int unsigned addr;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        put_char(random_printable());
      end else if (pick < 58) begin
        put_char(tccw_pkg::CHAR_NL);
      end else if (pick < 63) begin
        put_char(tccw_pkg::CHAR_CR);
      end else if (pick < 68) begin
        put_char(tccw_pkg::CHAR_BS);
      end else if (pick < 75) begin
        put_char(tccw_pkg::CHAR_TAB);
      end else if (pick < 92) begin
        if ($urandom_range(0, 1) == 0 || cursor_model < 40) addr = $urandom_range(0, 2047);
        else addr = cursor_model - $urandom_range(1, 40);
        read_cell(11'(addr));
      end else if (pick < 93) begin
        send_request(tccw_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end else if (pick < 96) begin
        send_request(FuncUnused, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     11'($urandom_range(0, 2047)));
      end else begin
        put_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 0;
    test_directed();
    finish_phase(20);

    write_blank_attr(8'hFF);
    sender_idle_pct = 59;
    test_scroll();
    finish_phase(20);

    write_blank_attr(8'h00);
    sender_idle_pct = 0;
    test_random_text(140);
    finish_phase(20);

    write_blank_attr(8'($urandom_range(1, 254)));
    sender_idle_pct = 59;
    test_random_text(140);
    finish_phase(20);

    write_blank_attr(8'($urandom_range(0, 255)));
    sender_idle_pct = 23;
    test_scroll();
    finish_phase(20);

    write_blank_attr(8'($urandom_range(0, 255)));
    test_random_text(140);
    finish_phase(2100);

    $display("Checked %0d results for %0d requests under %0d blank attribute settings",
             reports_checked, requests_sent, attr_settings);
    $display("Scrolls predicted: %0d, clears predicted: %0d, mismatches: %0d",
             scrolls_seen, clears_seen, errors);
    if (errors == 0 && expected_report_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_ram.sv
hw/rtl/text_console_cell_writer_core.sv
hw/rtl/tccw_checker.sv
bench/tb_text_console_cell_writer_core.sv
